/* src/hsb_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the histogram Bhattacharyya score block.
// No dependencies.
package hsb_pkg;

   localparam int MAX_SUPERPIXELS_DEFAULT = 64;
   localparam int MAX_BINS_DEFAULT        = 256;
   localparam int VALUE_BITS_DEFAULT      = 16;

   localparam int IDX_W     = 6;
   localparam int BIN_W     = 8;
   localparam int VAL_W     = 16;
   localparam int SCORE_W   = 24;
   localparam int NBINS_W   = 9;
   localparam int NSP_W     = 7;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 9;

   localparam logic [CSR_IDX_W-1:0] REG_BIN_COUNT        = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SUPERPIXEL_COUNT = 8'd1;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_PATCH = 1'b1;

   // tag traveling with each product through the root chain
   typedef struct packed {
      logic             vld;
      logic [IDX_W-1:0] idx;
      logic             last;
   } tag_type;

endpackage

/* src/hsb_req_if.sv */
`timescale 1ns / 1ps
// Request channel: load and patch bins.
// Depends on hsb_pkg.
interface hsb_req_if;
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic [hsb_pkg::IDX_W-1:0]  superpixel_index;
   logic [hsb_pkg::BIN_W-1:0]  bin_index;
   logic [hsb_pkg::VAL_W-1:0]  bin_value;
   modport source (output valid, operation, superpixel_index, bin_index, bin_value,
                   input ready);
   modport sink   (input valid, operation, superpixel_index, bin_index, bin_value,
                   output ready);
endinterface

/* src/hsb_rsp_if.sv */
`timescale 1ns / 1ps
// Result channel: one score per superpixel.
// Depends on hsb_pkg.
interface hsb_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hsb_pkg::IDX_W-1:0]    score_index;
   logic [hsb_pkg::SCORE_W-1:0]  score;
   logic                         last_score;
   modport source (output valid, score_index, score, last_score, input ready);
   modport sink   (input valid, score_index, score, last_score, output ready);
endinterface

/* src/hsb_csr_if.sv */
`timescale 1ns / 1ps
// Register write channel.
// Depends on hsb_pkg.
interface hsb_csr_if;
   logic                           valid;
   logic                           ready;
   logic [hsb_pkg::CSR_IDX_W-1:0]  index;
   logic [hsb_pkg::CSR_DAT_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* src/hsb_sqrt_cell.sv */
`timescale 1ns / 1ps
// One cell of the square root chain: resolves one root bit per cell.
// Depends on hsb_pkg.
module hsb_sqrt_cell #(
   parameter int VALUE_BITS = hsb_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  hsb_pkg::tag_type          tag_in,
   input  logic [2*VALUE_BITS-1:0]   rad_in,
   input  logic [VALUE_BITS+2:0]     rem_in,
   input  logic [VALUE_BITS-1:0]     root_in,
   output hsb_pkg::tag_type          tag_out,
   output logic [2*VALUE_BITS-1:0]   rad_out,
   output logic [VALUE_BITS+2:0]     rem_out,
   output logic [VALUE_BITS-1:0]     root_out
);
   localparam int RW = VALUE_BITS + 3;

   hsb_pkg::tag_type          tag_ff;
   logic [2*VALUE_BITS-1:0]   rad_ff, rad_in_nx;
   logic [RW-1:0]             rem_ff, rem_in_nx;
   logic [VALUE_BITS-1:0]     root_ff, root_in_nx;
   logic [RW-1:0]             rem_sh, trial;
   logic [RW:0]               diff;

   always_comb begin
      rem_sh     = {rem_in[RW-3:0], rad_in[2*VALUE_BITS-1 -: 2]};
      trial      = {1'b0, root_in, 2'b01};
      diff       = {1'b0, rem_sh} - {1'b0, trial};
      rad_in_nx  = {rad_in[2*VALUE_BITS-3:0], 2'b00};
      if (!diff[RW]) begin
         rem_in_nx  = diff[RW-1:0];
         root_in_nx = {root_in[VALUE_BITS-2:0], 1'b1};
      end else begin
         rem_in_nx  = rem_sh;
         root_in_nx = {root_in[VALUE_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.vld <= 1'b0;
      end else begin
         tag_ff.vld <= tag_in.vld;
      end
      tag_ff.idx  <= tag_in.idx;
      tag_ff.last <= tag_in.last;
      rad_ff      <= rad_in_nx;
      rem_ff      <= rem_in_nx;
      root_ff     <= root_in_nx;
   end

   assign tag_out  = tag_ff;
   assign rad_out  = rad_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;
endmodule

/* src/hsb_sqrt_chain.sv */
`timescale 1ns / 1ps
// Multiply stage followed by a row of root cells, one root bit per cell.
// Depends on hsb_pkg and hsb_sqrt_cell.
module hsb_sqrt_chain #(
   parameter int VALUE_BITS = hsb_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hsb_pkg::tag_type        tag_in,
   input  logic [VALUE_BITS-1:0]   a_in,
   input  logic [VALUE_BITS-1:0]   b_in,
   output hsb_pkg::tag_type        tag_out,
   output logic [VALUE_BITS-1:0]   root_out
);
   hsb_pkg::tag_type          tag_ff;
   logic [2*VALUE_BITS-1:0]   prod_ff;

   hsb_pkg::tag_type          tag_c  [VALUE_BITS+1];
   logic [2*VALUE_BITS-1:0]   rad_c  [VALUE_BITS+1];
   logic [VALUE_BITS+2:0]     rem_c  [VALUE_BITS+1];
   logic [VALUE_BITS-1:0]     root_c [VALUE_BITS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.vld <= 1'b0;
      end else begin
         tag_ff.vld <= tag_in.vld;
      end
      tag_ff.idx  <= tag_in.idx;
      tag_ff.last <= tag_in.last;
      prod_ff     <= a_in * b_in;
   end

   assign tag_c[0]  = tag_ff;
   assign rad_c[0]  = prod_ff;
   assign rem_c[0]  = '0;
   assign root_c[0] = '0;

   for (genvar i = 0; i < VALUE_BITS; i++) begin : g_cell
      hsb_sqrt_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tag_in  (tag_c[i]),
         .rad_in  (rad_c[i]),
         .rem_in  (rem_c[i]),
         .root_in (root_c[i]),
         .tag_out (tag_c[i+1]),
         .rad_out (rad_c[i+1]),
         .rem_out (rem_c[i+1]),
         .root_out(root_c[i+1])
      );
   end

   assign tag_out  = tag_c[VALUE_BITS];
   assign root_out = root_c[VALUE_BITS];
endmodule

/* src/histogram_bhattacharyya_scores_top.sv */
`timescale 1ns / 1ps
// Histogram Bhattacharyya scores: top level with store, sequencer and accumulators.
// Depends on hsb_pkg, the hsb_*_if interfaces and hsb_sqrt_chain.

// A load request writes one stored bin. A patch bin in range streams the stored
// bins of all superpixels in use, one per cycle, through a multiplier and a chain
// of VALUE_BITS root cells into the accumulators. The final bin then emits one
// score per superpixel; each score is read from the accumulators and then held on
// the output until it is taken. Requests are taken one at a time, only while no
// patch bin or emission is in progress.
module histogram_bhattacharyya_scores_top #(
   parameter int MAX_SUPERPIXELS = hsb_pkg::MAX_SUPERPIXELS_DEFAULT,
   parameter int MAX_BINS        = hsb_pkg::MAX_BINS_DEFAULT,
   parameter int VALUE_BITS      = hsb_pkg::VALUE_BITS_DEFAULT
) (
   input  logic  clock,
   input  logic  reset,
   hsb_req_if.sink   req_if,
   hsb_rsp_if.source rsp_if,
   hsb_csr_if.sink   csr_if
);
   localparam int SP_BITS   = (MAX_SUPERPIXELS > 1) ? $clog2(MAX_SUPERPIXELS) : 1;
   localparam int BIN_BITS  = $clog2(MAX_BINS);
   localparam int ADDR_BITS = SP_BITS + BIN_BITS;
   localparam int BIN_CAP   = (MAX_BINS < 256) ? MAX_BINS : 256;
   localparam int IW        = hsb_pkg::IDX_W;
   localparam int SW        = hsb_pkg::SCORE_W;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_RUN     = 3'd1;
   localparam logic [2:0] ST_DRAIN   = 3'd2;
   localparam logic [2:0] ST_EMIT_RD = 3'd3;
   localparam logic [2:0] ST_EMIT    = 3'd4;

   // configuration
   logic [hsb_pkg::NBINS_W-1:0] bin_count_ff;
   logic [hsb_pkg::NSP_W-1:0]   sp_count_ff;
   logic [hsb_pkg::NBINS_W-1:0] nbins;
   logic [hsb_pkg::NSP_W-1:0]   nsp;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff <= 9'd256;
         sp_count_ff  <= 7'd64;
      end else if (csr_if.valid) begin
         if (csr_if.index == hsb_pkg::REG_BIN_COUNT) begin
            bin_count_ff <= csr_if.data;
         end else if (csr_if.index == hsb_pkg::REG_SUPERPIXEL_COUNT) begin
            sp_count_ff <= csr_if.data[hsb_pkg::NSP_W-1:0];
         end
      end
   end

   always_comb begin
      if (bin_count_ff == '0) begin
         nbins = 9'd1;
      end else if (bin_count_ff > hsb_pkg::NBINS_W'(BIN_CAP)) begin
         nbins = hsb_pkg::NBINS_W'(BIN_CAP);
      end else begin
         nbins = bin_count_ff;
      end
      if (sp_count_ff == '0) begin
         nsp = 7'd1;
      end else if (sp_count_ff > hsb_pkg::NSP_W'(MAX_SUPERPIXELS)) begin
         nsp = hsb_pkg::NSP_W'(MAX_SUPERPIXELS);
      end else begin
         nsp = sp_count_ff;
      end
   end

   // control
   logic [2:0]            state_ff, state_in;
   logic [IW-1:0]         cnt_ff, cnt_in;
   logic [BIN_BITS-1:0]   bin_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic                  emit_ff, emit_in;
   logic                  accept, is_patch_ok, cnt_last;
   logic [9:0]            bin_ext;
   logic [VALUE_BITS-1:0] req_val;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign bin_ext      = {2'b00, req_if.bin_index};
   assign req_val      = VALUE_BITS'(req_if.bin_value);
   assign is_patch_ok  = (req_if.operation == hsb_pkg::OP_PATCH)
                         && ({1'b0, req_if.bin_index} < nbins);
   assign cnt_last     = ({1'b0, cnt_ff} == nsp - 7'd1);

   // superpixel bin store
   logic [VALUE_BITS-1:0] store_mem [1 << ADDR_BITS];
   logic [VALUE_BITS-1:0] store_rd_ff;
   hsb_pkg::tag_type      tag0_ff;
   logic                  load_ok;

   assign load_ok = (req_if.operation == hsb_pkg::OP_LOAD)
                    && ({1'b0, req_if.superpixel_index} < 7'(MAX_SUPERPIXELS))
                    && ({3'b000, req_if.bin_index} < 11'(MAX_BINS));

   always_ff @(posedge clock) begin
      if (accept && load_ok) begin
         store_mem[{req_if.superpixel_index[SP_BITS-1:0], bin_ext[BIN_BITS-1:0]}]
            <= req_val;
      end
      store_rd_ff <= store_mem[{cnt_ff[SP_BITS-1:0], bin_ff}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff.vld <= 1'b0;
      end else begin
         tag0_ff.vld <= (state_ff == ST_RUN);
      end
      tag0_ff.idx  <= cnt_ff;
      tag0_ff.last <= cnt_last;
   end

   // multiply and root chain
   hsb_pkg::tag_type      tag_sq;
   logic [VALUE_BITS-1:0] root_sq;

   hsb_sqrt_chain #(.VALUE_BITS(VALUE_BITS)) u_chain (
      .clock   (clock),
      .reset   (reset),
      .tag_in  (tag0_ff),
      .a_in    (val_ff),
      .b_in    (store_rd_ff),
      .tag_out (tag_sq),
      .root_out(root_sq)
   );

   // accumulators
   logic [SW-1:0]            acc_mem [MAX_SUPERPIXELS];
   logic [MAX_SUPERPIXELS-1:0] acc_vld_ff;
   logic [SW-1:0]            acc_rd_ff;
   logic                     accv_ff;
   hsb_pkg::tag_type         tag1_ff;
   logic [VALUE_BITS-1:0]    root1_ff;
   logic [SP_BITS-1:0]       acc_raddr, acc_waddr;
   logic                     acc_ren;
   logic [SW:0]              sum;
   logic [SW-1:0]            sum_sat, acc_val;

   assign acc_ren   = tag_sq.vld || (state_ff == ST_EMIT_RD);
   assign acc_raddr = tag_sq.vld ? tag_sq.idx[SP_BITS-1:0] : cnt_ff[SP_BITS-1:0];
   assign acc_waddr = tag1_ff.idx[SP_BITS-1:0];
   assign acc_val   = accv_ff ? acc_rd_ff : '0;
   assign sum       = {1'b0, acc_val} + (SW+1)'(root1_ff);
   assign sum_sat   = sum[SW] ? {SW{1'b1}} : sum[SW-1:0];

   always_ff @(posedge clock) begin
      if (acc_ren) begin
         acc_rd_ff <= acc_mem[acc_raddr];
         accv_ff   <= acc_vld_ff[acc_raddr];
      end
      if (tag1_ff.vld) begin
         acc_mem[acc_waddr] <= sum_sat;
      end
      root1_ff     <= root_sq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_vld_ff  <= '0;
         tag1_ff.vld <= 1'b0;
      end else begin
         tag1_ff.vld <= tag_sq.vld;
         if (accept && is_patch_ok && (req_if.bin_index == '0)) begin
            acc_vld_ff <= '0;  // bin 0 starts a new patch
         end else if (tag1_ff.vld) begin
            acc_vld_ff[acc_waddr] <= 1'b1;
         end
      end
      tag1_ff.idx  <= tag_sq.idx;
      tag1_ff.last <= tag_sq.last;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      emit_in  = emit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_patch_ok) begin
               state_in = ST_RUN;
               cnt_in   = '0;
               emit_in  = ({1'b0, req_if.bin_index} == nbins - 9'd1);
            end
         end
         ST_RUN: begin
            if (cnt_last) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + IW'(1);
            end
         end
         ST_DRAIN: begin
            if (tag1_ff.vld && tag1_ff.last) begin
               cnt_in   = '0;
               state_in = emit_ff ? ST_EMIT_RD : ST_IDLE;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_if.ready) begin
               if (cnt_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in   = cnt_ff + IW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         emit_ff  <= emit_in;
      end
      if (accept && is_patch_ok) begin
         bin_ff <= bin_ext[BIN_BITS-1:0];
         val_ff <= req_val;
      end
   end

   // results come straight from the registered accumulator read
   assign rsp_if.valid       = (state_ff == ST_EMIT);
   assign rsp_if.score_index = cnt_ff;
   assign rsp_if.score       = acc_val;
   assign rsp_if.last_score  = cnt_last;
endmodule

/* tb/histogram_bhattacharyya_scores_top_test.sv */
`timescale 1ns / 1ps
// Self-checking test of histogram_bhattacharyya_scores_top: loads superpixel bins, streams
// patch bins and compares every score against an in-bench similarity predictor.
// Depends on hsb_pkg, the hsb_*_if interfaces and the block itself.
module histogram_bhattacharyya_scores_top_test;

   localparam logic [hsb_pkg::CSR_IDX_W-1:0] REG_UNUSED = 8'hA5;
   localparam int SETTLE_CYCLES = 300;
   localparam int STALL_LIMIT   = 5000;
   localparam int LONG_HOLD     = 600;

   typedef struct {
      logic                      op;
      logic [hsb_pkg::IDX_W-1:0] sp;
      logic [hsb_pkg::BIN_W-1:0] bin;
      logic [hsb_pkg::VAL_W-1:0] val;
   } bin_request_type;

   typedef struct {
      logic [hsb_pkg::IDX_W-1:0]   idx;
      logic [hsb_pkg::SCORE_W-1:0] score;
      logic                        last;
   } score_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hsb_req_if req ();
   hsb_rsp_if rsp ();
   hsb_csr_if csr ();

   histogram_bhattacharyya_scores_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp),
      .csr_if (csr)
   );

   always #4 clock = ~clock;

   bin_request_type pending_bins[$];
   score_type       expected_scores[$];

   // predictor state
   logic [hsb_pkg::VAL_W-1:0]   stored_bins [64][256];
   logic [hsb_pkg::SCORE_W-1:0] score_acc [64];
   logic [hsb_pkg::NBINS_W-1:0] bin_count_reg;
   logic [hsb_pkg::NSP_W-1:0]   sp_count_reg;

   int  failures = 0;
   int  scores_seen = 0;
   int  patches_seen = 0;
   int  loads_seen = 0;
   int  quiet_cycles = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   bit  quiet = 0;
   bit  hold_req = 0;
   bit  hold_done = 0;

   function automatic int eff_bins(input logic [hsb_pkg::NBINS_W-1:0] r);
      if (r == 0) return 1;
      if (r > 256) return 256;
      return r;
   endfunction

   function automatic int eff_sps(input logic [hsb_pkg::NSP_W-1:0] r);
      if (r == 0) return 1;
      if (r > 64) return 64;
      return r;
   endfunction

   function automatic logic [15:0] floor_root(input logic [31:0] v);
      logic [31:0] rem;
      logic [31:0] root;
      logic [31:0] bitpos;
      rem = v;
      root = 0;
      bitpos = 32'h4000_0000;
      while (bitpos > rem) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
         if (rem >= root + bitpos) begin
            rem = rem - (root + bitpos);
            root = (root >> 1) + bitpos;
         end else begin
            root = root >> 1;
         end
         bitpos = bitpos >> 2;
      end
      return root[15:0];
   endfunction

   task automatic predict_scores(input bin_request_type r);
      int nb;
      int ns;
      logic [24:0] sum;
      score_type e;
      nb = eff_bins(bin_count_reg);
      ns = eff_sps(sp_count_reg);
      if (r.op == hsb_pkg::OP_LOAD) begin
         stored_bins[r.sp][r.bin] = r.val;
         loads_seen++;
         return;
      end
      if (r.bin >= nb) return;
      patches_seen++;
      if (r.bin == 0)
         for (int s = 0; s < 64; s++) score_acc[s] = '0;
      for (int s = 0; s < ns; s++) begin
         sum = score_acc[s] + floor_root(32'(r.val) * 32'(stored_bins[s][r.bin]));
         score_acc[s] = sum[24] ? 24'hFFFFFF : sum[23:0];
      end
      if (r.bin != nb - 1) return;
      for (int s = 0; s < ns; s++) begin
         e.idx = hsb_pkg::IDX_W'(s);
         e.score = score_acc[s];
         e.last = (s == ns - 1);
         expected_scores.push_back(e);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      bin_request_type r;
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req.ready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req.valid <= 1'b0;
         end else if (pending_bins.size() > 0) begin
            r = pending_bins.pop_front();
            req.valid <= 1'b1;
            req.operation <= r.op;
            req.superpixel_index <= r.sp;
            req.bin_index <= r.bin;
            req.bin_value <= r.val;
            if (!quiet && $urandom_range(0, 19) == 0) send_gap <= $urandom_range(1, 18);
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // result side back-pressure, including one long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
         hold_done <= 1'b1;
         stall_left <= LONG_HOLD;
         rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // tracking, checking and watchdog
   always @(posedge clock) begin
      bin_request_type r;
      score_type e;
      if (!reset) begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               hsb_pkg::REG_BIN_COUNT:
                  bin_count_reg = csr.data[hsb_pkg::NBINS_W-1:0];
               hsb_pkg::REG_SUPERPIXEL_COUNT:
                  sp_count_reg = csr.data[hsb_pkg::NSP_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            r.op = req.operation;
            r.sp = req.superpixel_index;
            r.bin = req.bin_index;
            r.val = req.bin_value;
            predict_scores(r);
         end
         if (rsp.valid && rsp.ready) begin
            scores_seen++;
            if (expected_scores.size() == 0) begin
               failures++;
               $display("%0t: unexpected score idx=%0d score=%0h last=%0b", $time,
                        rsp.score_index, rsp.score, rsp.last_score);
            end else begin
               e = expected_scores.pop_front();
               if (rsp.score_index !== e.idx || rsp.score !== e.score
                   || rsp.last_score !== e.last) begin
                  failures++;
                  $display("%0t: score mismatch expected idx=%0d score=%0h last=%0b",
                           $time, e.idx, e.score, e.last);
                  $display("%0t:                actual   idx=%0d score=%0h last=%0b",
                           $time, rsp.score_index, rsp.score, rsp.last_score);
               end
            end
         end
         if ((csr.valid && csr.ready) || (req.valid && req.ready)
             || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
         else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("histogram_bhattacharyya_scores_top_test NOT OK");
            $finish;
         end else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [hsb_pkg::CSR_IDX_W-1:0] idx, input int data);
      @(posedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= hsb_pkg::CSR_DAT_W'(data);
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      wait (pending_bins.size() == 0 && !req.valid && expected_scores.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_bin(input logic op, input int sp, input int bin, input int val);
      bin_request_type r;
      r.op = op;
      r.sp = hsb_pkg::IDX_W'(sp);
      r.bin = hsb_pkg::BIN_W'(bin);
      r.val = hsb_pkg::VAL_W'(val);
      pending_bins.push_back(r);
   endtask

   function automatic int rand_value();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 16'hFFFF;
         default: return $urandom_range(0, 16'hFFFF);
      endcase
   endfunction

   // one patch comparison: load the histograms, then stream the patch bins
   task automatic queue_patch(input int nb, input int ns);
      int order [256];
      int j;
      int t;
      for (int s = 0; s < ns; s++)
         for (int b = 0; b < nb; b++) push_bin(hsb_pkg::OP_LOAD, s, b, rand_value());
      for (int b = 0; b < nb; b++) order[b] = b;
      if ($urandom_range(0, 3) == 0) begin
         for (int b = nb - 1; b > 0; b--) begin
            j = $urandom_range(0, b);
            t = order[b]; order[b] = order[j]; order[j] = t;
         end
      end else begin
         // bin 0 first, final bin last, middle shuffled
         for (int b = nb - 2; b > 1; b--) begin
            j = $urandom_range(1, b);
            t = order[b]; order[b] = order[j]; order[j] = t;
         end
      end
      for (int b = 0; b < nb; b++) begin
         if (nb < 256 && $urandom_range(0, 7) == 0)
            push_bin(hsb_pkg::OP_PATCH, $urandom_range(0, 63), $urandom_range(nb, 255),
                     rand_value());
         if (ns < 64 && $urandom_range(0, 7) == 0)
            push_bin(hsb_pkg::OP_LOAD, $urandom_range(ns, 63), $urandom_range(0, 255),
                     rand_value());
         push_bin(hsb_pkg::OP_PATCH, $urandom_range(0, 63), order[b], rand_value());
      end
   endtask

   task automatic run_phase(input int bc, input int sc, input int sets);
      write_reg(hsb_pkg::REG_BIN_COUNT, bc);
      write_reg(hsb_pkg::REG_SUPERPIXEL_COUNT, sc);
      for (int k = 0; k < sets; k++) queue_patch(eff_bins(bc), eff_sps(sc));
      wait_idle();
   endtask

   initial begin
      req.valid = 1'b0;
      req.operation = hsb_pkg::OP_LOAD;
      req.superpixel_index = '0;
      req.bin_index = '0;
      req.bin_value = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.data = '0;
      bin_count_reg = 256;
      sp_count_reg = 64;
      for (int s = 0; s < 64; s++) score_acc[s] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // single bin, single superpixel: one bin both clears and emits
      write_reg(hsb_pkg::REG_BIN_COUNT, 1);
      write_reg(hsb_pkg::REG_SUPERPIXEL_COUNT, 1);
      push_bin(hsb_pkg::OP_LOAD, 0, 0, 16'hFFFF);
      push_bin(hsb_pkg::OP_PATCH, 0, 0, 16'hFFFF);
      push_bin(hsb_pkg::OP_LOAD, 0, 0, 0);
      push_bin(hsb_pkg::OP_PATCH, 63, 0, 16'hFFFF);
      push_bin(hsb_pkg::OP_PATCH, 0, 255, 16'hFFFF);
      push_bin(hsb_pkg::OP_LOAD, 63, 255, 16'hFFFF);
      push_bin(hsb_pkg::OP_LOAD, 0, 0, 16'h8001);
      push_bin(hsb_pkg::OP_PATCH, 0, 0, 16'h7FFF);
      wait_idle();
      // zero counts act as one; unknown register index is ignored
      write_reg(hsb_pkg::REG_BIN_COUNT, 0);
      write_reg(hsb_pkg::REG_SUPERPIXEL_COUNT, 0);
      write_reg(REG_UNUSED, 9'h1FF);
      push_bin(hsb_pkg::OP_PATCH, 0, 0, 16'h8000);
      push_bin(hsb_pkg::OP_PATCH, 0, 1, 16'h8000);
      wait_idle();

      run_phase(3, 4, 1);
      // oversized bin count clamps to 256, so bin 255 is the final bin
      write_reg(hsb_pkg::REG_BIN_COUNT, 300);
      write_reg(hsb_pkg::REG_SUPERPIXEL_COUNT, 1);
      push_bin(hsb_pkg::OP_LOAD, 0, 0, rand_value());
      push_bin(hsb_pkg::OP_LOAD, 0, 255, rand_value());
      push_bin(hsb_pkg::OP_PATCH, 0, 0, rand_value());
      push_bin(hsb_pkg::OP_PATCH, 0, 255, rand_value());
      wait_idle();
      // full superpixel set, receiver held off while more requests wait
      hold_req = 1;
      write_reg(hsb_pkg::REG_BIN_COUNT, 1);
      write_reg(hsb_pkg::REG_SUPERPIXEL_COUNT, 100);
      queue_patch(1, 64);
      push_bin(hsb_pkg::OP_PATCH, 0, 0, rand_value());
      wait_idle();
      quiet = 1;
      run_phase($urandom_range(1, 3), $urandom_range(1, 3), 1);

      $display("covered %0d loads, %0d patch bins in range, %0d scores checked",
               loads_seen, patches_seen, scores_seen);
      $display("bin counts 0..300 and superpixel counts 0..100, %0d failures", failures);
      if (failures == 0)
         $display("histogram_bhattacharyya_scores_top_test OK");
      else
         $display("histogram_bhattacharyya_scores_top_test NOT OK");
      $finish;
   end

endmodule
